FILE: src/vra_pkg.sv
`default_nettype none
package vra_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int TURN_W       = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int NORM_W       = 31;
  localparam int SQR_W        = 2 * NORM_W;
  localparam int SUM_W        = 64;
  localparam int MAG_W        = 32;
  localparam int QUO_W        = 31;
  localparam int CORD_W       = 34;
  localparam int UNIT_W       = 32;
  localparam int MAT_W        = 34;
  localparam int TERM_W       = 38;
  localparam int ACC_W        = 40;
  localparam int Q_SHIFT      = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;
  localparam logic signed [CORD_W-1:0] ONE_Q30   = 34'sh040000000;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] axis_a_x;
    logic signed [COORD_W-1:0] axis_a_y;
    logic signed [COORD_W-1:0] axis_a_z;
    logic signed [COORD_W-1:0] axis_b_x;
    logic signed [COORD_W-1:0] axis_b_y;
    logic signed [COORD_W-1:0] axis_b_z;
    logic [ANGLE_W-1:0]        angle;
  } vra_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
    logic                      zero_axis;
  } vra_out_t;

  // per-item data that rides along the whole pipe
  typedef struct packed {
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][DIFF_W-1:0]  p;
    logic [2:0]              neg;
    logic                    zero;
    logic                    flip;
    logic signed [CORD_W-1:0] z;
  } vra_side_t;

  function automatic logic [TURN_W-1:0] cordic_atan(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'h20000000;
      5'd1:  return 32'h12E4051E;
      5'd2:  return 32'h09FB385B;
      5'd3:  return 32'h051111D4;
      5'd4:  return 32'h028B0D43;
      5'd5:  return 32'h0145D7E1;
      5'd6:  return 32'h00A2F61E;
      5'd7:  return 32'h00517C55;
      5'd8:  return 32'h0028BE53;
      5'd9:  return 32'h00145F2F;
      5'd10: return 32'h000A2F98;
      5'd11: return 32'h000517CC;
      5'd12: return 32'h00028BE6;
      5'd13: return 32'h000145F3;
      5'd14: return 32'h0000A2FA;
      5'd15: return 32'h0000517D;
      5'd16: return 32'h000028BE;
      5'd17: return 32'h0000145F;
      5'd18: return 32'h00000A30;
      5'd19: return 32'h00000518;
      5'd20: return 32'h0000028C;
      5'd21: return 32'h00000146;
      5'd22: return 32'h000000A3;
      5'd23: return 32'h00000051;
      5'd24: return 32'h00000029;
      5'd25: return 32'h00000014;
      5'd26: return 32'h0000000A;
      5'd27: return 32'h00000005;
      5'd28: return 32'h00000003;
      5'd29: return 32'h00000001;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [CORD_W-1:0] v);
    if (v > ONE_Q30) return UNIT_W'(ONE_Q30);
    if (v < -ONE_Q30) return UNIT_W'(-ONE_Q30);
    return v[UNIT_W-1:0];
  endfunction

  // floor(a * b / 2^30)
  function automatic logic signed [UNIT_W-1:0] mul30(input logic signed [UNIT_W-1:0] a,
                                                     input logic signed [UNIT_W-1:0] b);
    logic signed [2*UNIT_W-1:0] pr;
    pr = a * b;
    return pr[Q_SHIFT+UNIT_W-1:Q_SHIFT];
  endfunction

endpackage
`default_nettype wire

FILE: src/vra_norm_cell.sv
`default_nettype none
module vra_norm_cell import vra_pkg::*; #(
  parameter int SH = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NORM_W-1:0]      m_i,
  input  logic [2:0][NORM_W-1:0] mg_i,
  output logic [NORM_W-1:0]      m_o,
  output logic [2:0][NORM_W-1:0] mg_o
);

  logic                   sh;
  logic [NORM_W-1:0]      m_r, m_nxt;
  logic [2:0][NORM_W-1:0] mg_r, mg_nxt;

  always_comb begin
    sh = (m_i[NORM_W-1 -: SH] == '0);
    m_nxt = sh ? (m_i << SH) : m_i;
    for (int i = 0; i < 3; i++) begin
      mg_nxt[i] = sh ? (mg_i[i] << SH) : mg_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_nxt;
      mg_r <= mg_nxt;
    end
  end

  assign m_o  = m_r;
  assign mg_o = mg_r;

endmodule
`default_nettype wire

FILE: src/vra_sqrt_cell.sv
`default_nettype none
module vra_sqrt_cell import vra_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] n_i,
  input  logic [SUM_W-1:0] res_i,
  output logic [SUM_W-1:0] n_o,
  output logic [SUM_W-1:0] res_o
);

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * STEP);

  logic [SUM_W-1:0] trial;
  logic             ge;
  logic [SUM_W-1:0] n_r, n_nxt, res_r, res_nxt;

  always_comb begin
    trial   = res_i + BIT;
    ge      = (n_i >= trial);
    n_nxt   = ge ? (n_i - trial) : n_i;
    res_nxt = ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
    end
  end

  assign n_o   = n_r;
  assign res_o = res_r;

endmodule
`default_nettype wire

FILE: src/vra_div_cell.sv
`default_nettype none
module vra_div_cell import vra_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0][MAG_W-1:0] rem_i,
  input  logic [2:0][QUO_W-1:0] q_i,
  input  logic [2:0]            din_i,
  input  logic [MAG_W-1:0]      mag_i,
  output logic [2:0][MAG_W-1:0] rem_o,
  output logic [2:0][QUO_W-1:0] q_o,
  output logic [MAG_W-1:0]      mag_o
);

  logic [2:0][MAG_W:0]   r2;
  logic [2:0]            ge;
  logic [2:0][MAG_W-1:0] rem_r, rem_nxt;
  logic [2:0][QUO_W-1:0] q_r, q_nxt;
  logic [MAG_W-1:0]      mag_r;

  // one restoring step per lane, all three lanes share the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i]      = {rem_i[i], din_i[i]};
      ge[i]      = (r2[i] >= {1'b0, mag_i});
      rem_nxt[i] = ge[i] ? MAG_W'(r2[i] - {1'b0, mag_i}) : r2[i][MAG_W-1:0];
      q_nxt[i]   = {q_i[i][QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      mag_r <= mag_i;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign mag_o = mag_r;

endmodule
`default_nettype wire

FILE: src/vra_cordic_cell.sv
`default_nettype none
module vra_cordic_cell import vra_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [CORD_W-1:0] z_i,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output logic signed [CORD_W-1:0] z_o
);

  localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(cordic_atan(5'(STEP)));

  logic signed [CORD_W-1:0] xs, ys;
  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[CORD_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

FILE: src/vector_rotate_about_axis_top.sv
// channel | valid     | stall     | payload            | direction
// in      | in_valid  | in_stall  | in_data  vra_in_t  | to block
// out     | out_valid | out_stall | out_data vra_out_t | from block
//
// one point per cycle unless a held result on out stalls the pipe; the pipe depth
// is set by the 32-step square-root chain and the 31-step divider chain that
// normalise the axis, plus the matrix stages
// reset (rst_n, synchronous) clears only the stage valid bits
// a held result on out stalls every stage at once, in_stall follows it
// the trig chain runs beside the divider chain, its cos and sin meet the quotients at the same stage
`default_nettype none
module vector_rotate_about_axis_top import vra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vra_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vra_out_t out_data
);

  localparam int NS       = 78;
  localparam int NSIDE    = 77;
  localparam int ST_NORM  = 6;
  localparam int ST_CORD0 = 41;
  localparam int ST_DIV   = 71;
  localparam int ST_M1    = 72;
  localparam int ST_M4    = 75;
  localparam int ST_M5    = 76;

  logic [NS-1:0] vld_r;
  logic          en;

  assign en        = !vld_r[NS-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // input stage: differences, magnitudes, angle fold
  logic signed [COORD_W-1:0] pt_c [3];
  logic signed [COORD_W-1:0] aa_c [3];
  logic signed [COORD_W-1:0] bb_c [3];
  logic signed [DIFF_W-1:0]  dd_c [3];
  logic [TURN_W-1:0]         ang_c;
  logic                      flip_c;
  vra_side_t                 side_nxt;
  logic [2:0][DIFF_W-1:0]    mg_nxt;

  always_comb begin
    pt_c[0] = in_data.point_x;  pt_c[1] = in_data.point_y;  pt_c[2] = in_data.point_z;
    aa_c[0] = in_data.axis_a_x; aa_c[1] = in_data.axis_a_y; aa_c[2] = in_data.axis_a_z;
    bb_c[0] = in_data.axis_b_x; bb_c[1] = in_data.axis_b_y; bb_c[2] = in_data.axis_b_z;
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = {bb_c[i][COORD_W-1], bb_c[i]} - {aa_c[i][COORD_W-1], aa_c[i]};
      side_nxt.p[i]   = {pt_c[i][COORD_W-1], pt_c[i]} - {aa_c[i][COORD_W-1], aa_c[i]};
      side_nxt.a[i]   = aa_c[i];
      side_nxt.neg[i] = dd_c[i][DIFF_W-1];
      mg_nxt[i]       = dd_c[i][DIFF_W-1] ? -dd_c[i] : dd_c[i];
    end
    side_nxt.zero = (mg_nxt == '0);
    ang_c  = {in_data.angle, {(TURN_W-ANGLE_W){1'b0}}};
    // second and third quadrant: turn by a half and negate at the end
    flip_c = ang_c[TURN_W-1] ^ ang_c[TURN_W-2];
    side_nxt.flip = flip_c;
    side_nxt.z = {{(CORD_W-TURN_W+1){ang_c[TURN_W-1] ^ flip_c}}, ang_c[TURN_W-2:0]};
  end

  vra_side_t              side_r [NSIDE];
  logic [2:0][DIFF_W-1:0] mg0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < NSIDE; k++) begin
        side_r[k] <= side_r[k-1];
      end
      mg0_r <= mg_nxt;
    end
  end

  // coarse right shift so the largest magnitude fits below 2^31
  logic [DIFF_W-1:0]      mx_c;
  logic [NORM_W-1:0]      nm1_r, nm1_nxt;
  logic [2:0][NORM_W-1:0] nmg1_r, nmg1_nxt;

  always_comb begin
    mx_c = mg0_r[0];
    if (mg0_r[1] > mx_c) mx_c = mg0_r[1];
    if (mg0_r[2] > mx_c) mx_c = mg0_r[2];
    if (mx_c[DIFF_W-1]) begin
      nm1_nxt = mx_c[DIFF_W-1:2];
      for (int i = 0; i < 3; i++) nmg1_nxt[i] = mg0_r[i][DIFF_W-1:2];
    end else if (mx_c[DIFF_W-2]) begin
      nm1_nxt = mx_c[DIFF_W-2:1];
      for (int i = 0; i < 3; i++) nmg1_nxt[i] = mg0_r[i][DIFF_W-2:1];
    end else begin
      nm1_nxt = mx_c[NORM_W-1:0];
      for (int i = 0; i < 3; i++) nmg1_nxt[i] = mg0_r[i][NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm1_r  <= nm1_nxt;
      nmg1_r <= nmg1_nxt;
    end
  end

  logic [NORM_W-1:0]      nm  [1:5];
  logic [2:0][NORM_W-1:0] nmg [1:5];

  for (genvar k = 0; k < 5; k++) begin : g_norm
    logic [NORM_W-1:0]      m_in;
    logic [2:0][NORM_W-1:0] mg_in;
    if (k == 0) begin : g_first
      assign m_in  = nm1_r;
      assign mg_in = nmg1_r;
    end else begin : g_next
      assign m_in  = nm[k];
      assign mg_in = nmg[k];
    end
    vra_norm_cell #(.SH(16 >> k)) u_cell (
      .clk  (clk),
      .en   (en),
      .m_i  (m_in),
      .mg_i (mg_in),
      .m_o  (nm[k+1]),
      .mg_o (nmg[k+1])
    );
  end

  // squares and their sum
  logic [2:0][SQR_W-1:0]  sq_r;
  logic [2:0][NORM_W-1:0] mgq_r;
  logic [SUM_W-1:0]       n_r;
  logic [2:0][NORM_W-1:0] mgd_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= nmg[5][i] * nmg[5][i];
      mgq_r    <= nmg[5];
      n_r      <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      mgd_r[0] <= mgq_r;
      for (int k = 1; k <= SQRT_STEPS; k++) mgd_r[k] <= mgd_r[k-1];
    end
  end

  logic [SUM_W-1:0] sn   [1:SQRT_STEPS];
  logic [SUM_W-1:0] sres [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SUM_W-1:0] n_in, res_in;
    if (k == 0) begin : g_first
      assign n_in   = n_r;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = sn[k];
      assign res_in = sres[k];
    end
    vra_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .n_i   (n_in),
      .res_i (res_in),
      .n_o   (sn[k+1]),
      .res_o (sres[k+1])
    );
  end

  logic [2:0][MAG_W-1:0] drem [1:DIV_STEPS];
  logic [2:0][QUO_W-1:0] dq   [1:DIV_STEPS];
  logic [MAG_W-1:0]      dmag [1:DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [2:0][MAG_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] q_in;
    logic [2:0]            din;
    logic [MAG_W-1:0]      mag_in;
    if (k == 0) begin : g_first
      // dividend is mg << 30: start from mg >> 1 with its lsb as the next bit
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = MAG_W'(mgd_r[SQRT_STEPS][i][NORM_W-1:1]);
        assign din[i]    = mgd_r[SQRT_STEPS][i][0];
      end
      assign q_in   = '0;
      assign mag_in = sres[SQRT_STEPS][MAG_W-1:0];
    end else begin : g_next
      assign rem_in = drem[k];
      assign q_in   = dq[k];
      assign din    = '0;
      assign mag_in = dmag[k];
    end
    vra_div_cell u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_in),
      .q_i   (q_in),
      .din_i (din),
      .mag_i (mag_in),
      .rem_o (drem[k+1]),
      .q_o   (dq[k+1]),
      .mag_o (dmag[k+1])
    );
  end

  logic signed [CORD_W-1:0] cx [1:CORDIC_STEPS];
  logic signed [CORD_W-1:0] cy [1:CORDIC_STEPS];
  logic signed [CORD_W-1:0] cz [1:CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CORD_W-1:0] x_in, y_in, z_in;
    if (k == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = side_r[ST_CORD0].z;
    end else begin : g_next
      assign x_in = cx[k];
      assign y_in = cy[k];
      assign z_in = cz[k];
    end
    vra_cordic_cell #(.STEP(k)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (x_in),
      .y_i (y_in),
      .z_i (z_in),
      .x_o (cx[k+1]),
      .y_o (cy[k+1]),
      .z_o (cz[k+1])
    );
  end

  // unit vector, cos, sin and 1 - cos
  logic signed [UNIT_W-1:0] u_r [3], u_nxt [3];
  logic signed [UNIT_W-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [UNIT_W:0]   t_r, t_nxt;
  logic signed [CORD_W-1:0] xf_c, yf_c;
  logic signed [UNIT_W-1:0] qv_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv_c[i]  = {1'b0, dq[DIV_STEPS][i]};
      u_nxt[i] = side_r[ST_DIV].zero ? '0 : (side_r[ST_DIV].neg[i] ? -qv_c[i] : qv_c[i]);
    end
    xf_c  = side_r[ST_DIV].flip ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    yf_c  = side_r[ST_DIV].flip ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
    c_nxt = clamp_unit(xf_c);
    s_nxt = clamp_unit(yf_c);
    t_nxt = (UNIT_W+1)'(ONE_Q30) - (UNIT_W+1)'(c_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
      c_r <= c_nxt;
      s_r <= s_nxt;
      t_r <= t_nxt;
    end
  end

  // u_i * u_j in order xx yy zz xy xz yz, and u_k * s
  logic signed [UNIT_W-1:0] uu_r [6];
  logic signed [UNIT_W-1:0] us_r [3];
  logic signed [UNIT_W-1:0] c2_r;
  logic signed [UNIT_W:0]   t2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r[0] <= mul30(u_r[0], u_r[0]);
      uu_r[1] <= mul30(u_r[1], u_r[1]);
      uu_r[2] <= mul30(u_r[2], u_r[2]);
      uu_r[3] <= mul30(u_r[0], u_r[1]);
      uu_r[4] <= mul30(u_r[0], u_r[2]);
      uu_r[5] <= mul30(u_r[1], u_r[2]);
      for (int k = 0; k < 3; k++) us_r[k] <= mul30(u_r[k], s_r);
      c2_r <= c_r;
      t2_r <= t_r;
    end
  end

  logic signed [2*UNIT_W:0] tp_c [6];
  logic signed [MAT_W-1:0]  tm_r [6];
  logic signed [UNIT_W-1:0] us3_r [3];
  logic signed [UNIT_W-1:0] c3_r;

  always_comb begin
    for (int k = 0; k < 6; k++) tp_c[k] = t2_r * uu_r[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) tm_r[k] <= tp_c[k][Q_SHIFT+MAT_W-1:Q_SHIFT];
      us3_r <= us_r;
      c3_r  <= c2_r;
    end
  end

  // rotation matrix, row major
  logic signed [MAT_W-1:0] m_r [9], m_nxt [9];

  always_comb begin
    m_nxt[0] = tm_r[0] + MAT_W'(c3_r);
    m_nxt[4] = tm_r[1] + MAT_W'(c3_r);
    m_nxt[8] = tm_r[2] + MAT_W'(c3_r);
    m_nxt[1] = tm_r[3] - MAT_W'(us3_r[2]);
    m_nxt[3] = tm_r[3] + MAT_W'(us3_r[2]);
    m_nxt[2] = tm_r[4] + MAT_W'(us3_r[1]);
    m_nxt[6] = tm_r[4] - MAT_W'(us3_r[1]);
    m_nxt[5] = tm_r[5] - MAT_W'(us3_r[0]);
    m_nxt[7] = tm_r[5] + MAT_W'(us3_r[0]);
  end

  always_ff @(posedge clk) begin
    if (en) m_r <= m_nxt;
  end

  // matrix times offset, the offset split at bit 30 to keep each product narrow
  logic [DIFF_W-1:0]                pj_c [3];
  logic signed [MAT_W+Q_SHIFT:0]    lo_c [9];
  logic signed [MAT_W+2:0]          hi_c [9];
  logic signed [TERM_W-1:0]         term_r [9], term_nxt [9];

  always_comb begin
    for (int j = 0; j < 3; j++) pj_c[j] = side_r[ST_M4].p[j];
    for (int e = 0; e < 9; e++) begin
      lo_c[e] = m_r[e] * $signed({1'b0, pj_c[e % 3][Q_SHIFT-1:0]});
      hi_c[e] = m_r[e] * $signed(pj_c[e % 3][DIFF_W-1:Q_SHIFT]);
      term_nxt[e] = TERM_W'(hi_c[e]) +
                    TERM_W'($signed(lo_c[e][MAT_W+Q_SHIFT:Q_SHIFT]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) term_r <= term_nxt;
  end

  logic signed [ACC_W-1:0]   acc_c [3];
  logic signed [COORD_W-1:0] sat_c [3];
  vra_out_t                  out_r, out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_c[i] = ACC_W'($signed(side_r[ST_M5].a[i])) + ACC_W'(term_r[3*i]) +
                 ACC_W'(term_r[3*i+1]) + ACC_W'(term_r[3*i+2]);
      if (acc_c[i] > $signed(ACC_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
        sat_c[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (acc_c[i] < -$signed(ACC_W'({1'b0, 1'b1, {(COORD_W-1){1'b0}}}))) begin
        sat_c[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat_c[i] = acc_c[i][COORD_W-1:0];
      end
    end
    out_nxt.rotated_x = sat_c[0];
    out_nxt.rotated_y = sat_c[1];
    out_nxt.rotated_z = sat_c[2];
    out_nxt.zero_axis = side_r[ST_M5].zero;
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_norm_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_NORM] && !side_r[ST_NORM].zero |-> nm[5][NORM_W-1])
    else $error("normalised axis magnitude lost its top bit");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DIV] && !side_r[ST_DIV].zero |->
      (drem[DIV_STEPS][0] < dmag[DIV_STEPS]) && (drem[DIV_STEPS][1] < dmag[DIV_STEPS]) &&
      (drem[DIV_STEPS][2] < dmag[DIV_STEPS]))
    else $error("divider remainder not below the axis magnitude");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DIV] && en |=>
      (c_r <= UNIT_W'(ONE_Q30)) && (c_r >= -UNIT_W'(ONE_Q30)) &&
      (s_r <= UNIT_W'(ONE_Q30)) && (s_r >= -UNIT_W'(ONE_Q30)))
    else $error("cos or sin outside the unit range");

  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_M1] && side_r[ST_M1].zero |->
      (u_r[0] == '0) && (u_r[1] == '0) && (u_r[2] == '0))
    else $error("zero axis gave a non-zero direction");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
